// ===== rtl/siphash_4_8_keyed_hash_defines.svh =====
// Assertion macros for the SipHash-4-8 block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef SIPHASH_4_8_KEYED_HASH_DEFINES_SVH
`define SIPHASH_4_8_KEYED_HASH_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define SIP48_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define SIP48_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== rtl/sip48_pkg.sv =====
// Shared types, constants and the SipRound function for the SipHash-4-8 block.
// No dependencies.
`timescale 1ns / 1ps

package sip48_pkg;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

  localparam int unsigned CROUNDS    = 4;
  localparam int unsigned DROUNDS    = 8;
  localparam int unsigned RND_W      = $clog2(DROUNDS);
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned TDATA_W    = 72;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(1);

  typedef logic [3:0][63:0] lanes_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic        full;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_sts_t;

  typedef struct packed {
    logic busy;
    logic emit;
  } back_sts_t;

  function automatic lanes_t sip_round(input lanes_t v);
    logic [63:0] a, b, c, d;
    lanes_t r;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b;
    b = {b[50:0], b[63:51]};
    b = b ^ a;
    a = {a[31:0], a[63:32]};
    c = c + d;
    d = {d[47:0], d[63:48]};
    d = d ^ c;
    a = a + d;
    d = {d[42:0], d[63:43]};
    d = d ^ a;
    c = c + b;
    b = {b[46:0], b[63:47]};
    b = b ^ c;
    c = {c[31:0], c[63:32]};
    r[0] = a;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

  function automatic lanes_t key_lanes(input logic [63:0] k0, input logic [63:0] k1);
    lanes_t r;
    r[0] = k0 ^ SIP_C0;
    r[1] = k1 ^ SIP_C1;
    r[2] = k0 ^ SIP_C2;
    r[3] = k1 ^ SIP_C3;
    return r;
  endfunction

endpackage

// ===== rtl/siphash_4_8_keyed_hash.sv =====
// SipHash-4-8 keyed hash. The round engine dequeues a word and runs four compression
// rounds; a full last word adds the length block, then any last word gets finalization
// rounds before the hash is registered. New words are taken only when idle: all rounds
// share the single SipRound unit. Reset clears the key to zero, loads the lanes with the
// bare constants, clears the byte count and empties the queue; no clearing pass needed.
`timescale 1ns / 1ps

module siphash_4_8_keyed_hash #(
  parameter int unsigned FIFO_DEPTH = sip48_pkg::FIFO_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [63:0] message_word, [67:64] valid_bytes, [71:68] zero
  input  logic [sip48_pkg::TDATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [63:0] hash
  output logic [63:0]                       m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sip48_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [63:0]                       cfg_data_i
);
  import sip48_pkg::*;
  `include "siphash_4_8_keyed_hash_defines.svh"

  fifo_sts_t fifo_sts;
  back_sts_t back_sts;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      push;
  logic      pop;

  assign cfg_ready_o = 1'b1;

  sip48_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .fifo_sts_i      (fifo_sts),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  sip48_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .sts_o  (fifo_sts)
  );

  sip48_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fifo_sts_i      (fifo_sts),
    .cmd_i           (head_cmd),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .hash_o          (m_axis_tdata),
    .sts_o           (back_sts)
  );

  `SIP48_ASSERT(a_no_push_full, !(push && fifo_sts.full), "push into full queue")
  `SIP48_ASSERT_IMP(a_pop_busy_free, pop, !fifo_sts.empty && !back_sts.busy, "bad dequeue")
  `SIP48_ASSERT_IMP(a_result_from_emit, $rose(m_axis_tvalid), $past(back_sts.emit),
                    "result without finalization")

endmodule

// ===== rtl/sip48_front.sv =====
// Input side: accepts message words, clamps the byte count and masks tail bytes.
// Depends on sip48_pkg; feeds the command queue.
`timescale 1ns / 1ps

module sip48_front (
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [63:0] message_word, [67:64] valid_bytes, [71:68] zero
  input  logic [sip48_pkg::TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,
  input  sip48_pkg::fifo_sts_t            fifo_sts_i,
  output logic                            push_o,
  output sip48_pkg::cmd_t                 cmd_o
);
  import sip48_pkg::*;

  logic [63:0] word;
  logic [3:0]  nb_raw;
  logic [3:0]  nb;
  logic [63:0] masked;

  assign word   = s_axis_tdata_i[63:0];
  assign nb_raw = s_axis_tdata_i[67:64];
  assign nb     = (nb_raw > 4'd8) ? 4'd8 : nb_raw;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[i*8 +: 8] = (4'(i) < nb) ? word[i*8 +: 8] : 8'h00;
    end
  end

  assign s_axis_tready_o = !fifo_sts_i.full;
  assign push_o          = s_axis_tvalid_i && !fifo_sts_i.full;

  always_comb begin
    cmd_o.last   = s_axis_tlast_i;
    cmd_o.full   = !s_axis_tlast_i || (nb == 4'd8);
    cmd_o.nbytes = nb;
    cmd_o.word   = cmd_o.full ? word : masked;
  end

endmodule

// ===== rtl/sip48_fifo.sv =====
// Short command queue between the input side and the round engine.
// Depends on sip48_pkg.
`timescale 1ns / 1ps

module sip48_fifo #(
  parameter int unsigned DEPTH = sip48_pkg::FIFO_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sip48_pkg::cmd_t       cmd_i,
  input  logic                  pop_i,
  output sip48_pkg::cmd_t       cmd_o,
  output sip48_pkg::fifo_sts_t  sts_o
);
  import sip48_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign sts_o.full  = (cnt_q == CW'(DEPTH));
  assign sts_o.empty = (cnt_q == '0);
  assign do_push     = push_i && !sts_o.full;
  assign do_pop      = pop_i && !sts_o.empty;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/sip48_back.sv =====
// Round engine: one shared SipRound per cycle while computing, key registers, byte count, result register.
// Depends on sip48_pkg; takes commands from the queue.
`timescale 1ns / 1ps

module sip48_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [sip48_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [63:0]                       cfg_data_i,
  input  sip48_pkg::fifo_sts_t              fifo_sts_i,
  input  sip48_pkg::cmd_t                   cmd_i,
  output logic                              pop_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [63:0]                       hash_o,
  output sip48_pkg::back_sts_t              sts_o
);
  import sip48_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMP,
    ST_FIN,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  lanes_t           lanes_q, lanes_d;
  lanes_t           rnd_out;
  logic [63:0]      k0_q, k0_d, k1_q, k1_d;
  logic [63:0]      m_q, m_d;
  logic [63:0]      m_new;
  logic [7:0]       cnt_q, cnt_d;
  logic [7:0]       cnt_new;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic             tail_q, tail_d;
  logic             fin_q, fin_d;
  logic             out_valid_q, out_valid_d;
  logic [63:0]      hash_q, hash_d;

  assign rnd_out         = sip_round(lanes_q);
  assign m_axis_tvalid_o = out_valid_q;
  assign hash_o          = hash_q;
  assign sts_o.busy      = (state_q != ST_IDLE);
  assign sts_o.emit      = (state_q == ST_EMIT);

  always_comb begin
    state_d     = state_q;
    lanes_d     = lanes_q;
    k0_d        = k0_q;
    k1_d        = k1_q;
    m_d         = m_q;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    tail_d      = tail_q;
    fin_d       = fin_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    pop_o       = 1'b0;
    cnt_new     = cnt_q;
    m_new       = m_q;

    case (state_q)
      ST_IDLE: begin
        if (!fifo_sts_i.empty) begin
          pop_o = 1'b1;
          rnd_d = '0;
          if (cmd_i.full) begin
            cnt_new = cnt_q + 8'd8;
            m_new   = cmd_i.word;
            tail_d  = cmd_i.last;
            fin_d   = 1'b0;
          end else begin
            cnt_new = cnt_q + {4'b0000, cmd_i.nbytes};
            m_new   = cmd_i.word | {cnt_new, 56'b0};
            tail_d  = 1'b0;
            fin_d   = 1'b1;
          end
          cnt_d      = cnt_new;
          m_d        = m_new;
          lanes_d[3] = lanes_q[3] ^ m_new;
          state_d    = ST_COMP;
        end
      end
      ST_COMP: begin
        lanes_d = rnd_out;
        rnd_d   = rnd_q + RND_W'(1);
        if (rnd_q == RND_W'(CROUNDS - 1)) begin
          rnd_d      = '0;
          lanes_d[0] = rnd_out[0] ^ m_q;
          if (tail_q) begin
            m_new      = {cnt_q, 56'b0};
            m_d        = m_new;
            lanes_d[3] = rnd_out[3] ^ m_new;
            tail_d     = 1'b0;
            fin_d      = 1'b1;
          end else if (fin_q) begin
            lanes_d[2] = rnd_out[2] ^ 64'hff;
            fin_d      = 1'b0;
            state_d    = ST_FIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        lanes_d = rnd_out;
        rnd_d   = rnd_q + RND_W'(1);
        if (rnd_q == RND_W'(DROUNDS - 1)) begin
          rnd_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          hash_d      = lanes_q[0] ^ lanes_q[1] ^ lanes_q[2] ^ lanes_q[3];
          out_valid_d = 1'b1;
          lanes_d     = key_lanes(k0_q, k1_q);
          cnt_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_valid_i && (cfg_index_i == CFG_KEY_LOW || cfg_index_i == CFG_KEY_HIGH)) begin
      if (cfg_index_i == CFG_KEY_LOW) begin
        k0_d = cfg_data_i;
      end else begin
        k1_d = cfg_data_i;
      end
      lanes_d = key_lanes(k0_d, k1_d);
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lanes_q     <= key_lanes(64'd0, 64'd0);
      k0_q        <= '0;
      k1_q        <= '0;
      cnt_q       <= '0;
      rnd_q       <= '0;
      tail_q      <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lanes_q     <= lanes_d;
      k0_q        <= k0_d;
      k1_q        <= k1_d;
      cnt_q       <= cnt_d;
      rnd_q       <= rnd_d;
      tail_q      <= tail_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    hash_q <= hash_d;
  end

endmodule
